// ----- rtl/vss_pkg.sv -----
// shared types, codes and helpers of the voice session sequencer
`default_nettype none

package vss_pkg;

  localparam int unsigned EvW    = 5;
  localparam int unsigned PhaseW = 4;
  localparam int unsigned ActW   = 4;
  localparam int unsigned WordW  = 32;

  localparam logic [EvW-1:0] EV_DISABLE   = 5'd0;
  localparam logic [EvW-1:0] EV_FAULT     = 5'd1;
  localparam logic [EvW-1:0] EV_CANCEL    = 5'd2;
  localparam logic [EvW-1:0] EV_FAILURE   = 5'd3;
  localparam logic [EvW-1:0] EV_TIMEOUT   = 5'd4;
  localparam logic [EvW-1:0] EV_ENABLE    = 5'd5;
  localparam logic [EvW-1:0] EV_FE_READY  = 5'd6;
  localparam logic [EvW-1:0] EV_WAKE      = 5'd7;
  localparam logic [EvW-1:0] EV_PTT_BEGIN = 5'd8;
  localparam logic [EvW-1:0] EV_REC_START = 5'd9;
  localparam logic [EvW-1:0] EV_UTT_READY = 5'd10;
  localparam logic [EvW-1:0] EV_PTT_END   = 5'd11;
  localparam logic [EvW-1:0] EV_UPLOADING = 5'd12;
  localparam logic [EvW-1:0] EV_CLOUD     = 5'd13;
  localparam logic [EvW-1:0] EV_PARSED    = 5'd14;
  localparam logic [EvW-1:0] EV_ACCEPTED  = 5'd15;
  localparam logic [EvW-1:0] EV_REJECTED  = 5'd16;
  localparam logic [EvW-1:0] EV_PLAY_DONE = 5'd17;

  localparam logic [PhaseW-1:0] PH_DISABLED = 4'd0;
  localparam logic [PhaseW-1:0] PH_IDLE     = 4'd1;
  localparam logic [PhaseW-1:0] PH_LISTEN   = 4'd2;
  localparam logic [PhaseW-1:0] PH_WAKE     = 4'd3;
  localparam logic [PhaseW-1:0] PH_RECORD   = 4'd4;
  localparam logic [PhaseW-1:0] PH_UPLOAD   = 4'd5;
  localparam logic [PhaseW-1:0] PH_WAIT     = 4'd6;
  localparam logic [PhaseW-1:0] PH_PARSE    = 4'd7;
  localparam logic [PhaseW-1:0] PH_SUBMIT   = 4'd8;
  localparam logic [PhaseW-1:0] PH_SPEAK    = 4'd9;
  localparam logic [PhaseW-1:0] PH_ERROR    = 4'd10;

  localparam logic [ActW-1:0] ACT_NONE     = 4'd0;
  localparam logic [ActW-1:0] ACT_CANCEL   = 4'd1;
  localparam logic [ActW-1:0] ACT_PLAY_ERR = 4'd2;
  localparam logic [ActW-1:0] ACT_FRONTEND = 4'd3;
  localparam logic [ActW-1:0] ACT_RECORD   = 4'd4;
  localparam logic [ActW-1:0] ACT_UPLOAD   = 4'd5;
  localparam logic [ActW-1:0] ACT_PARSE    = 4'd6;
  localparam logic [ActW-1:0] ACT_SUBMIT   = 4'd7;
  localparam logic [ActW-1:0] ACT_PLAY_OK  = 4'd8;
  localparam logic [ActW-1:0] ACT_PLAY_NO  = 4'd9;

  typedef struct packed {
    logic [EvW-1:0]   event_code;
    logic [WordW-1:0] detail_word;
  } vss_in_t;

  typedef struct packed {
    logic [ActW-1:0]   action_code;
    logic [PhaseW-1:0] phase_out;
    logic              was_accepted;
    logic [WordW-1:0]  generation_out;
    logic [WordW-1:0]  utterance_out;
    logic [WordW-1:0]  error_out;
    logic              terminal_out;
  } vss_out_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [WordW-1:0]  generation;
    logic [WordW-1:0]  utterance;
    logic [WordW-1:0]  error_detail;
    logic              terminal_flag;
  } vss_state_t;

  // counter step that skips zero on wrap
  function automatic logic [WordW-1:0] bump(input logic [WordW-1:0] v);
    logic [WordW-1:0] s;
    s = v + {{(WordW-1){1'b0}}, 1'b1};
    return (s == '0) ? {{(WordW-1){1'b0}}, 1'b1} : s;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/vss_in_if.sv -----
// input channel: event item with valid/ready handshake
`default_nettype none

interface vss_in_if;
  import vss_pkg::*;

  logic    valid;
  logic    ready;
  vss_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/vss_out_if.sv -----
// output channel: result item with valid/ready handshake
`default_nettype none

interface vss_out_if;
  import vss_pkg::*;

  logic     valid;
  logic     ready;
  vss_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/vss_step.sv -----
// phase transition table and counter update for one event item
`default_nettype none

module vss_step (
  input  wire vss_pkg::vss_state_t cur,
  input  wire vss_pkg::vss_in_t    item,
  output vss_pkg::vss_state_t      nxt,
  output vss_pkg::vss_out_t        res
);
  import vss_pkg::*;

  logic [ActW-1:0] act;
  logic            ok;
  logic [EvW-1:0]  ev;

  assign ev = item.event_code;

  always_comb begin
    nxt = cur;
    act = ACT_NONE;
    ok  = 1'b1;
    if (ev == EV_DISABLE) begin
      nxt.generation    = bump(cur.generation);
      nxt.terminal_flag = 1'b0;
      nxt.phase         = PH_DISABLED;
      act               = ACT_CANCEL;
    end else if (ev == EV_FAULT) begin
      nxt.error_detail  = item.detail_word;
      nxt.terminal_flag = 1'b0;
      nxt.phase         = PH_ERROR;
      act               = ACT_CANCEL;
    end else if (ev == EV_CANCEL) begin
      nxt.generation    = bump(cur.generation);
      nxt.terminal_flag = 1'b0;
      nxt.phase         = PH_IDLE;
      act               = ACT_CANCEL;
    end else if (ev == EV_FAILURE || ev == EV_TIMEOUT) begin
      nxt.error_detail  = item.detail_word;
      nxt.terminal_flag = 1'b0;
      nxt.phase         = PH_ERROR;
      act               = ACT_PLAY_ERR;
    end else if ((ev == EV_PTT_BEGIN && cur.phase inside
                  {PH_LISTEN, PH_WAIT, PH_PARSE, PH_SUBMIT, PH_SPEAK, PH_ERROR}) ||
                 (ev == EV_WAKE && cur.phase inside {PH_LISTEN, PH_ERROR})) begin
      nxt.utterance     = bump(cur.utterance);
      nxt.terminal_flag = 1'b0;
      nxt.phase         = PH_WAKE;
      act               = ACT_RECORD;
    end else if (ev == EV_PLAY_DONE && cur.phase inside {PH_SPEAK, PH_ERROR}) begin
      nxt.terminal_flag = 1'b0;
      nxt.phase         = PH_IDLE;
      act               = ACT_FRONTEND;
    end else if (cur.phase == PH_DISABLED && ev == EV_ENABLE) begin
      nxt.generation    = bump(cur.generation);
      nxt.terminal_flag = 1'b0;
      nxt.phase         = PH_IDLE;
      act               = ACT_FRONTEND;
    end else if (cur.phase == PH_IDLE && ev == EV_FE_READY) begin
      nxt.phase = PH_LISTEN;
    end else if (cur.phase == PH_WAKE && ev == EV_REC_START) begin
      nxt.phase = PH_RECORD;
    end else if (cur.phase == PH_RECORD && (ev == EV_UTT_READY || ev == EV_PTT_END)) begin
      nxt.phase = PH_UPLOAD;
      act       = ACT_UPLOAD;
    end else if (cur.phase == PH_UPLOAD && ev == EV_UPLOADING) begin
      nxt.phase = PH_WAIT;
    end else if (cur.phase == PH_WAIT && ev == EV_CLOUD) begin
      nxt.phase = PH_PARSE;
      act       = ACT_PARSE;
    end else if (cur.phase == PH_PARSE && ev == EV_PARSED) begin
      nxt.phase = PH_SUBMIT;
      act       = ACT_SUBMIT;
    end else if (cur.phase == PH_SUBMIT && ev == EV_ACCEPTED) begin
      nxt.terminal_flag = 1'b1;
      nxt.phase         = PH_SPEAK;
      act               = ACT_PLAY_OK;
    end else if (cur.phase == PH_SUBMIT && ev == EV_REJECTED) begin
      nxt.terminal_flag = 1'b1;
      nxt.phase         = PH_SPEAK;
      act               = ACT_PLAY_NO;
    end else begin
      ok = 1'b0;
    end
  end

  always_comb begin
    res.action_code    = act;
    res.phase_out      = nxt.phase;
    res.was_accepted   = ok;
    res.generation_out = nxt.generation;
    res.utterance_out  = nxt.utterance;
    res.error_out      = nxt.error_detail;
    res.terminal_out   = nxt.terminal_flag;
  end

endmodule

`default_nettype wire

// ----- rtl/voice_session_sequencer.sv -----
// top level of the voice session sequencer
`default_nettype none

// The sequencer takes one event item per clock cycle and returns exactly one
// result item for each, in the cycle after the event is accepted. The session
// state (phase, generation and utterance counters, error word, terminal flag)
// is updated in the same cycle that the event is accepted, so consecutive
// events chain with no gap. The result sits in an output register; in_item
// stays ready while that register is empty or being taken in the same cycle,
// so a stalled consumer holds back new events only while its result waits.
// Rejected events return action none with the state unchanged.

module voice_session_sequencer (
  input  wire logic clk,
  input  wire logic rst,
  vss_in_if.sink    in_item,
  vss_out_if.source out_item
);
  import vss_pkg::*;

  vss_state_t state;
  vss_state_t state_next;
  vss_out_t   result;
  vss_out_t   res_next;
  logic       res_valid;
  logic       take;

  vss_step u_step (
    .cur  (state),
    .item (in_item.payload),
    .nxt  (state_next),
    .res  (res_next)
  );

  assign in_item.ready    = !res_valid || out_item.ready;
  assign take             = in_item.valid && in_item.ready;
  assign out_item.valid   = res_valid;
  assign out_item.payload = result;

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase         <= PH_DISABLED;
      state.generation    <= '0;
      state.utterance     <= '0;
      state.error_detail  <= '0;
      state.terminal_flag <= 1'b0;
      res_valid           <= 1'b0;
    end else begin
      if (take) begin
        state     <= state_next;
        res_valid <= 1'b1;
      end else if (out_item.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= res_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/vss_checker.sv -----
// port checks of the voice session sequencer and their binding
`default_nettype none

module vss_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire vss_pkg::vss_out_t out_payload
);
  import vss_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("result item changed while stalled");

  a_reject_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_payload.was_accepted |-> out_payload.action_code == ACT_NONE)
    else $error("rejected item requests an action");

  a_error_entry: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_payload.was_accepted && out_payload.phase_out == PH_ERROR
    |-> out_payload.action_code == ACT_CANCEL || out_payload.action_code == ACT_PLAY_ERR)
    else $error("error phase entered without cancel or error prompt");

  a_terminal_speak: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_payload.terminal_out |-> out_payload.phase_out == PH_SPEAK)
    else $error("terminal flag outside speaking phase");

  a_accept_next: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item produced no result");

endmodule

bind voice_session_sequencer vss_checker u_vss_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_item.valid),
  .in_ready    (in_item.ready),
  .out_valid   (out_item.valid),
  .out_ready   (out_item.ready),
  .out_payload (out_item.payload)
);

`default_nettype wire
